>>> rtl/liu_pkg.sv
// ----------------------------------------------------------------------------
// liu_pkg
// Shared constants and types for the linear interpolation upsampler.
// ----------------------------------------------------------------------------
package liu_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAX_FACTOR   = 16;

    localparam int FACTOR_W     = 13;
    localparam int PHASE_W      = 8;
    localparam int FACTOR_RESET = 512;
    localparam int FACTOR_MIN   = 256;
    localparam int FACTOR_MAX   = MAX_FACTOR * 256;

    localparam int DIFF_W    = SAMPLE_WIDTH + 1;
    localparam int GAP_W     = $clog2(MAX_FACTOR + 1);
    localparam int ACC_W     = DIFF_W + GAP_W;
    localparam int SPAN_W    = $clog2(FACTOR_MAX + 256);
    localparam int SUM_W     = ((FACTOR_W > SPAN_W) ? FACTOR_W : SPAN_W) + 1;
    localparam int DIV_CNT_W = $clog2(ACC_W + 1);

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

>>> rtl/linear_interp_upsampler_core.sv
// ----------------------------------------------------------------------------
// linear_interp_upsampler_core
// Fractional-factor linear interpolation upsampler for signed mono samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel takes one sample per transaction with a last flag. m_ channel
//   gives original and interpolated samples; m_last_of_run marks the final
//   result caused by one input. cfg_ channel writes the Q5.8 factor and is
//   always ready; write it only between streams or while idle.
//   Each input after the first of a stream yields g results (g = gap,
//   1..MAX_FACTOR): the previous sample, then g-1 interpolated values.
//   Every interpolated value comes from a bit-serial divider, and the
//   divider sets how long an input occupies the sequencer. An input that
//   only starts a stream is taken without giving a result. A last input
//   adds a final result, the sample itself.
//   Results pass through one output register, so the next input is taken
//   while the final result still waits. When m_ready is low the sequencer
//   holds in place until the output register frees up.
//   Reset (aresetn low, synchronous) sets the factor to 2.0, clears the
//   stream state and empties the output register.
// ----------------------------------------------------------------------------
module linear_interp_upsampler_core
    import liu_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [FACTOR_W-1:0]            cfg_factor_q8,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_in,
    input  logic                           s_last_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_sample_out,
    output logic                           m_last_of_run
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EMIT_PREV,
        ST_DIV,
        ST_EMIT_INT,
        ST_EMIT_CUR
    } state_t;

    state_t                   state_reg;
    logic [FACTOR_W-1:0]      factor_reg;
    logic [SAMPLE_WIDTH-1:0]  prev_reg;
    logic [SAMPLE_WIDTH-1:0]  cur_reg;
    logic                     last_reg;
    logic                     have_prev_reg;
    logic [PHASE_W-1:0]       phase_reg;
    logic [GAP_W-1:0]         g_reg;
    logic [GAP_W-1:0]         j_reg;
    logic signed [ACC_W-1:0]  diff_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     div_start_reg;
    logic                     m_valid_reg;
    logic [SAMPLE_WIDTH-1:0]  m_sample_reg;
    logic                     m_last_reg;

    logic [SUM_W-1:0]         f_wide;
    logic [SUM_W-1:0]         f_clamp;
    logic [SUM_W-1:0]         phase_sum;
    logic [GAP_W-1:0]         g_next;
    logic signed [ACC_W-1:0]  diff_next;
    logic [ACC_W-1:0]         acc_mag;
    logic [ACC_W-1:0]         quotient;
    logic signed [ACC_W-1:0]  q_signed;
    logic signed [ACC_W-1:0]  interp_sum;
    logic [GAP_W-1:0]         j_inc;
    logic                     out_free;
    logic                     s_accept;
    div_status_t              div_status;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;

    always_comb begin
        f_wide = SUM_W'(factor_reg);
        if (f_wide < SUM_W'(FACTOR_MIN)) begin
            f_clamp = SUM_W'(FACTOR_MIN);
        end else if (f_wide > SUM_W'(FACTOR_MAX)) begin
            f_clamp = SUM_W'(FACTOR_MAX);
        end else begin
            f_clamp = f_wide;
        end
        phase_sum = SUM_W'(phase_reg) + f_clamp;
        g_next    = GAP_W'(phase_sum >> PHASE_W);
        diff_next = ACC_W'(signed'(s_sample_in)) - ACC_W'(signed'(prev_reg));
        acc_mag   = acc_reg[ACC_W-1] ? ACC_W'(-acc_reg) : ACC_W'(acc_reg);
        q_signed  = acc_reg[ACC_W-1] ? -signed'(quotient) : signed'(quotient);
        interp_sum = ACC_W'(signed'(prev_reg)) + q_signed;
        j_inc     = j_reg + 1'b1;
    end

    liu_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start_reg),
        .dividend (acc_mag),
        .divisor  (g_reg),
        .quotient (quotient),
        .status   (div_status)
    );

    always_ff @(posedge aclk) begin
        if (cfg_valid && cfg_ready) begin
            factor_reg <= cfg_factor_q8;
        end
        if (!aresetn) begin
            factor_reg <= FACTOR_W'(FACTOR_RESET);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            prev_reg      <= '0;
            have_prev_reg <= 1'b0;
            phase_reg     <= '0;
            div_start_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            div_start_reg <= 1'b0;
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        cur_reg  <= s_sample_in;
                        last_reg <= s_last_sample;
                        if (have_prev_reg) begin
                            g_reg     <= g_next;
                            phase_reg <= phase_sum[PHASE_W-1:0];
                            diff_reg  <= diff_next;
                            acc_reg   <= diff_next;
                            j_reg     <= GAP_W'(1);
                            state_reg <= ST_EMIT_PREV;
                        end else begin
                            phase_reg <= '0;
                            prev_reg  <= s_sample_in;
                            if (s_last_sample) begin
                                state_reg <= ST_EMIT_CUR;
                            end else begin
                                have_prev_reg <= 1'b1;
                            end
                        end
                    end
                end
                ST_EMIT_PREV: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_sample_reg <= prev_reg;
                        m_last_reg   <= (g_reg == GAP_W'(1)) && !last_reg;
                        if (g_reg != GAP_W'(1)) begin
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_DIV;
                        end else if (last_reg) begin
                            state_reg <= ST_EMIT_CUR;
                        end else begin
                            prev_reg  <= cur_reg;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_DIV: begin
                    if (div_status.done) begin
                        state_reg <= ST_EMIT_INT;
                    end
                end
                ST_EMIT_INT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_sample_reg <= interp_sum[SAMPLE_WIDTH-1:0];
                        m_last_reg   <= (j_inc == g_reg) && !last_reg;
                        if (j_inc != g_reg) begin
                            j_reg         <= j_inc;
                            acc_reg       <= acc_reg + diff_reg;
                            div_start_reg <= 1'b1;
                            state_reg     <= ST_DIV;
                        end else if (last_reg) begin
                            state_reg <= ST_EMIT_CUR;
                        end else begin
                            prev_reg  <= cur_reg;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_EMIT_CUR: begin
                    if (out_free) begin
                        m_valid_reg   <= 1'b1;
                        m_sample_reg  <= cur_reg;
                        m_last_reg    <= 1'b1;
                        prev_reg      <= cur_reg;
                        have_prev_reg <= 1'b0;
                        phase_reg     <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_sample_out  = m_sample_reg;
    assign m_last_of_run = m_last_reg;

`ifndef SYNTHESIS
    // divider results only show up while the sequencer waits for them
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_status.done |-> state_reg == ST_DIV)
        else $error("divider finished outside of divide state");

    // interpolation index stays below the gap
    a_j_below_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV || state_reg == ST_EMIT_INT) |-> j_reg < g_reg)
        else $error("interpolation index reached the gap");

    // gap lies in 1..MAX_FACTOR while a run is emitted
    a_gap_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT_PREV) |->
            (g_reg != '0 && g_reg <= GAP_W'(MAX_FACTOR)))
        else $error("gap out of range");

    // no stream open means no accumulated phase
    a_phase_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (!have_prev_reg && state_reg == ST_IDLE) |-> phase_reg == '0)
        else $error("phase left over with no stream open");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |=> $stable(m_sample_reg))
        else $error("pending output overwritten");
`endif

endmodule

>>> rtl/liu_divider.sv
// ----------------------------------------------------------------------------
// liu_divider
// Bit-serial restoring divider: unsigned magnitude by the gap, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
module liu_divider
    import liu_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [ACC_W-1:0] dividend,
    input  logic [GAP_W-1:0] divisor,
    output logic [ACC_W-1:0] quotient,
    output div_status_t      status
);

    logic [GAP_W-1:0]     rem_reg;
    logic [ACC_W-1:0]     quo_reg;
    logic [GAP_W-1:0]     div_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic [GAP_W:0]       shifted;
    logic                 ge;
    logic [GAP_W:0]       diff_w;
    logic [GAP_W-1:0]     rem_next;

    always_comb begin
        shifted  = {rem_reg, quo_reg[ACC_W-1]};
        ge       = (shifted >= {1'b0, div_reg});
        diff_w   = shifted - {1'b0, div_reg};
        rem_next = ge ? diff_w[GAP_W-1:0] : shifted[GAP_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[ACC_W-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(ACC_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end else begin
            done_reg <= 1'b0;
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

>>> test/linear_interp_upsampler_checker.sv
// ----------------------------------------------------------------------------
// linear_interp_upsampler_checker
// Watches the config, sample and result channels of the upsampler. On each
// accepted input it works out the output run and compares every accepted
// result with the oldest pending one.
// ----------------------------------------------------------------------------
module linear_interp_upsampler_checker
    import liu_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [FACTOR_W-1:0]            cfg_factor_q8,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_in,
    input  logic                           s_last_sample,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] m_sample_out,
    input  logic                           m_last_of_run,
    output int                             mismatch_count,
    output int                             pending_count
);

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] sample;
        logic                           last;
    } upsample_result_t;

    upsample_result_t expected_q[$];

    logic [FACTOR_W-1:0]            factor_setting;
    logic signed [SAMPLE_WIDTH-1:0] held_sample;
    logic                           holding;
    logic [PHASE_W-1:0]             frac_phase;
    int                             error_total = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $time, what);
        error_total++;
    endtask

    // queue up the run of samples one input produces
    function automatic void predict_run(input logic signed [SAMPLE_WIDTH-1:0] cur,
                                        input logic is_last);
        int eff_factor;
        int phase_sum;
        int gap;
        int diff;
        int count;
        int k;
        int value;
        upsample_result_t item;
        gap = 0;
        if (holding) begin
            eff_factor = int'(factor_setting);
            if (eff_factor < FACTOR_MIN) eff_factor = FACTOR_MIN;
            if (eff_factor > FACTOR_MAX) eff_factor = FACTOR_MAX;
            phase_sum  = int'(frac_phase) + eff_factor;
            gap        = phase_sum / 256;
            frac_phase = phase_sum[PHASE_W-1:0];
        end else begin
            frac_phase = '0;
        end
        count = gap + (is_last ? 1 : 0);
        diff  = int'(cur) - int'(held_sample);
        // k = 0 is the held sample itself, the rest are interpolated
        for (k = 0; k < gap; k++) begin
            value       = int'(held_sample) + (diff * k) / gap;
            item.sample = value[SAMPLE_WIDTH-1:0];
            item.last   = (k == count - 1);
            expected_q.push_back(item);
        end
        if (is_last) begin
            item.sample = cur;
            item.last   = 1'b1;
            expected_q.push_back(item);
            frac_phase  = '0;
        end
        held_sample = cur;
        holding     = !is_last;
    endfunction

    always @(posedge aclk) begin
        upsample_result_t want;
        if (!aresetn) begin
            factor_setting = FACTOR_W'(FACTOR_RESET);
            held_sample    = '0;
            holding        = 1'b0;
            frac_phase     = '0;
            expected_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d last=%0b",
                                              m_sample_out, m_last_of_run));
                end else begin
                    want = expected_q.pop_front();
                    if (m_sample_out !== want.sample) begin
                        report_mismatch($sformatf("sample_out %0d, wanted %0d",
                                                  m_sample_out, want.sample));
                    end
                    if (m_last_of_run !== want.last) begin
                        report_mismatch($sformatf("last_of_run %0b, wanted %0b",
                                                  m_last_of_run, want.last));
                    end
                end
            end
            // a sample taken on the same edge as a factor write still sees the old factor
            if (s_valid && s_ready) begin
                predict_run(s_sample_in, s_last_sample);
            end
            if (cfg_valid && cfg_ready) begin
                factor_setting = cfg_factor_q8;
            end
        end
        pending_count  <= expected_q.size();
        mismatch_count <= error_total;
    end

endmodule

>>> test/linear_interp_upsampler_core_tb.sv
// ----------------------------------------------------------------------------
// linear_interp_upsampler_core_tb
// Drives sample streams through the upsampler under a range of factors,
// including out-of-range ones and a change in the middle of a stream, with
// random gaps on both sides and one long output stall. A checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module linear_interp_upsampler_core_tb;
    import liu_pkg::*;

    localparam int STALL_LIMIT     = 2000;
    localparam int LONG_HOLD       = 300;
    localparam int IDLE_SETTLE     = 8;
    localparam int END_SETTLE      = 60;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 17;
    localparam int HOLD_PHASE      = 2;
    localparam int SIDE_SEND       = 0;
    localparam int SIDE_RECV       = 1;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    logic                           aclk          = 1'b0;
    logic                           aresetn       = 1'b0;
    logic                           cfg_valid     = 1'b0;
    logic                           cfg_ready;
    logic [FACTOR_W-1:0]            cfg_factor_q8 = FACTOR_W'(FACTOR_RESET);
    logic                           s_valid       = 1'b0;
    logic                           s_ready;
    logic signed [SAMPLE_WIDTH-1:0] s_sample_in   = '0;
    logic                           s_last_sample = 1'b0;
    logic                           m_valid;
    logic                           m_ready       = 1'b0;
    logic signed [SAMPLE_WIDTH-1:0] m_sample_out;
    logic                           m_last_of_run;

    int mismatch_count;
    int pending_count;
    int quiet_cycles = 0;
    int quiet_left[2] = '{0, 0};

    bit offering       = 1'b0;
    bit accepting      = 1'b0;
    bit sender_no_gaps = 1'b0;
    bit hold_request   = 1'b0;

    logic signed [SAMPLE_WIDTH-1:0] recent_sample = '0;

    always #5 aclk = ~aclk;

    linear_interp_upsampler_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_factor_q8 (cfg_factor_q8),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_in   (s_sample_in),
        .s_last_sample (s_last_sample),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_out  (m_sample_out),
        .m_last_of_run (m_last_of_run)
    );

    linear_interp_upsampler_checker upsample_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_factor_q8  (cfg_factor_q8),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample_in    (s_sample_in),
        .s_last_sample  (s_last_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_sample_out   (m_sample_out),
        .m_last_of_run  (m_last_of_run),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    // random wait with occasional stretches of back-to-back transactions
    function automatic int draw_wait(input int side);
        if (quiet_left[side] > 0) begin
            quiet_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            quiet_left[side] = $urandom_range(10, 30);
            return 0;
        end
        return $urandom_range(0, 11);
    endfunction

    function automatic logic signed [SAMPLE_WIDTH-1:0] next_sample();
        logic signed [SAMPLE_WIDTH-1:0] v;
        case ($urandom_range(0, 7))
            0:       v = SAMPLE_MIN;
            1:       v = SAMPLE_MAX;
            2, 3, 4: v = SAMPLE_WIDTH'($urandom);
            default: v = recent_sample + SAMPLE_WIDTH'($urandom_range(0, 64) - 32);
        endcase
        recent_sample = v;
        return v;
    endfunction

    task automatic stop_offering();
        if (offering) begin
            s_valid  <= 1'b0;
            offering = 1'b0;
        end
    endtask

    // valid stays up across back-to-back transactions
    task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] value,
                               input logic is_last);
        int gap;
        gap = sender_no_gaps ? 0 : draw_wait(SIDE_SEND);
        if (gap > 0) begin
            stop_offering();
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        offering      = 1'b1;
        s_sample_in   <= value;
        s_last_sample <= is_last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        stop_offering();
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
    endtask

    task automatic write_factor(input logic [FACTOR_W-1:0] value);
        drain_results();
        // a stream-opening sample leaves nothing pending but may still be in flight
        repeat (IDLE_SETTLE) @(posedge aclk);
        cfg_valid     <= 1'b1;
        cfg_factor_q8 <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // result side
    initial begin
        int stall;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                stall        = LONG_HOLD;
            end else begin
                stall = draw_wait(SIDE_RECV);
            end
            if (stall > 0) begin
                if (accepting) begin
                    m_ready   <= 1'b0;
                    accepting = 1'b0;
                end
                repeat (stall) @(posedge aclk);
            end
            if (!accepting) begin
                m_ready   <= 1'b1;
                accepting = 1'b1;
            end
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int phase_idx;
        int n;
        int stream_left;
        logic [FACTOR_W-1:0] factor;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // reset factor of 2.0, stream across the sample extremes
        send_sample('0, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample(16'sd1, 1'b1);

        // unity factor: only the held samples come out
        write_factor(FACTOR_W'(FACTOR_MIN));
        send_sample(16'sd100, 1'b0);
        send_sample(-16'sd100, 1'b1);

        // zero factor is clamped up; lone sample that is also last
        write_factor('0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(16'sd5, 1'b0);
        send_sample(16'sd7, 1'b1);

        // widest gap with full-scale swings
        write_factor(FACTOR_W'(FACTOR_MAX));
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);

        // all ones is clamped down to the widest gap
        write_factor('1);
        send_sample(16'sd1, 1'b0);
        send_sample(-16'sd1, 1'b0);
        send_sample('0, 1'b1);

        // fractional factor, then a change in the middle of the stream
        write_factor(FACTOR_W'(383));
        send_sample(16'sd1000, 1'b0);
        send_sample(-16'sd2000, 1'b0);
        send_sample(16'sd3000, 1'b0);
        write_factor(FACTOR_W'(640));
        send_sample(-16'sd4000, 1'b0);
        send_sample(16'sd5000, 1'b0);
        send_sample(-16'sd6000, 1'b1);

        stream_left = 0;
        for (phase_idx = 0; phase_idx < RAND_PHASES; phase_idx++) begin
            case ($urandom_range(0, 5))
                0:       factor = FACTOR_W'($urandom);
                1:       factor = FACTOR_W'(FACTOR_MAX);
                default: factor = FACTOR_W'($urandom_range(FACTOR_MIN, 3 * FACTOR_MIN));
            endcase
            write_factor(factor);
            // receiver stalls hard while the sender keeps pushing
            if (phase_idx == HOLD_PHASE) begin
                sender_no_gaps = 1'b1;
                hold_request   = 1'b1;
            end
            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (stream_left == 0) stream_left = $urandom_range(1, 12);
                stream_left--;
                send_sample(next_sample(), stream_left == 0);
            end
            sender_no_gaps = 1'b0;
        end

        drain_results();
        repeat (END_SETTLE) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/liu_pkg.sv
rtl/liu_divider.sv
rtl/linear_interp_upsampler_core.sv
test/linear_interp_upsampler_checker.sv
test/linear_interp_upsampler_core_tb.sv
